[design/kec_pkg.sv]
package kec_pkg;

   // key codes
   localparam logic [7:0] KEY_NONE  = 8'd255;
   localparam logic [7:0] KEY_EQ    = 8'd61;
   localparam logic [7:0] KEY_PLUS  = 8'd43;
   localparam logic [7:0] KEY_MINUS = 8'd45;
   localparam logic [7:0] KEY_STAR  = 8'd42;
   localparam logic [7:0] KEY_SLASH = 8'd47;
   localparam logic [7:0] KEY_CLEAR = 8'd99;
   localparam logic [7:0] KEY_ZERO  = 8'd48;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned STEP_W = $clog2(DATA_W);

   // result status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_NOOP = 2'd2;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_NONE
   } op_type;

   typedef struct packed {
      logic              start;
      op_type            op;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] value;
      logic [1:0]        status;
   } alu_rsp_type;

endpackage

[design/kec_alu.sv]
// Shared arithmetic unit: add/sub in one step, shift-add multiply and
// restoring divide one bit per cycle.
module kec_alu
   import kec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   typedef enum logic [2:0] {
      A_IDLE,
      A_PREP,
      A_MUL,
      A_DIV,
      A_FIX
   } alu_state_type;

   alu_state_type     state_ff, state_in;
   op_type            op_ff, op_in;
   logic [DATA_W-1:0] a_ff, a_in;      // multiplicand / dividend-quotient
   logic [DATA_W-1:0] b_ff, b_in;      // multiplier / divisor
   logic [DATA_W-1:0] acc_ff, acc_in;  // product / remainder
   logic [STEP_W-1:0] count_ff, count_in;
   logic              neg_ff, neg_in;
   logic              valid_ff, valid_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [1:0]        status_ff, status_in;

   logic [DATA_W-1:0] shifted;
   logic [DATA_W:0]   trial;
   logic              last_step;

   assign shifted   = {acc_ff[DATA_W-2:0], a_ff[DATA_W-1]};
   assign trial     = {1'b0, shifted} - {1'b0, b_ff};
   assign last_step = (count_ff == STEP_W'(DATA_W - 1));

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      acc_in    = acc_ff;
      count_in  = count_ff;
      neg_in    = neg_ff;
      valid_in  = valid_ff;
      value_in  = value_ff;
      status_in = status_ff;

      unique case (state_ff)
         A_IDLE: begin
            if (req.start) begin
               op_in    = req.op;
               a_in     = req.a;
               b_in     = req.b;
               valid_in = 1'b0;
               state_in = A_PREP;
            end
         end
         A_PREP: begin
            count_in  = '0;
            acc_in    = '0;
            status_in = ST_OK;
            unique case (op_ff)
               OP_ADD: begin
                  value_in = a_ff + b_ff;
                  valid_in = 1'b1;
                  state_in = A_IDLE;
               end
               OP_SUB: begin
                  value_in = a_ff - b_ff;
                  valid_in = 1'b1;
                  state_in = A_IDLE;
               end
               OP_MUL: begin
                  state_in = A_MUL;
               end
               OP_DIV: begin
                  if (b_ff == '0) begin
                     value_in  = '0;
                     status_in = ST_DIV0;
                     valid_in  = 1'b1;
                     state_in  = A_IDLE;
                  end else begin
                     // work on magnitudes, fix the sign at the end
                     neg_in   = a_ff[DATA_W-1] ^ b_ff[DATA_W-1];
                     a_in     = a_ff[DATA_W-1] ? -a_ff : a_ff;
                     b_in     = b_ff[DATA_W-1] ? -b_ff : b_ff;
                     state_in = A_DIV;
                  end
               end
               default: begin
                  value_in  = '0;
                  status_in = ST_NOOP;
                  valid_in  = 1'b1;
                  state_in  = A_IDLE;
               end
            endcase
         end
         A_MUL: begin
            acc_in   = b_ff[0] ? acc_ff + a_ff : acc_ff;
            a_in     = {a_ff[DATA_W-2:0], 1'b0};
            b_in     = {1'b0, b_ff[DATA_W-1:1]};
            count_in = count_ff + 1'b1;
            if (last_step) begin
               value_in = acc_in;
               valid_in = 1'b1;
               state_in = A_IDLE;
            end
         end
         A_DIV: begin
            if (!trial[DATA_W]) begin
               acc_in = trial[DATA_W-1:0];
               a_in   = {a_ff[DATA_W-2:0], 1'b1};
            end else begin
               acc_in = shifted;
               a_in   = {a_ff[DATA_W-2:0], 1'b0};
            end
            count_in = count_ff + 1'b1;
            if (last_step) begin
               state_in = A_FIX;
            end
         end
         A_FIX: begin
            value_in = neg_ff ? -a_ff : a_ff;
            valid_in = 1'b1;
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      op_ff     <= op_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      acc_ff    <= acc_in;
      count_ff  <= count_in;
      neg_ff    <= neg_in;
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   assign rsp.valid  = valid_ff;
   assign rsp.value  = value_ff;
   assign rsp.status = status_ff;

   // result is never flagged while a calculation is running
   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (state_ff == A_IDLE))
      else $error("alu result valid while busy");

   // a divide by zero result reads zero
   a_div0_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && status_ff == ST_DIV0) |-> (value_ff == '0))
      else $error("divide by zero result not zero");

   // start clears the previous result
   a_start_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == A_IDLE && req.start) |=> !valid_ff)
      else $error("stale alu result after start");

endmodule

[design/keypad_expression_calculator_unit.sv]
// Channel  Dir  Ports                        Word
// req      in   req_tvalid/tready/tdata      key_code [7:0]
// rsp      out  rsp_tvalid/tready/tdata      result_value [31:0], result_status [33:32]
//
// A key that is not '=' is taken without a wait; ready stays high after it.
// '=' runs the shared ALU: add/sub, multiply, divide, or a zero result with a status
// for no operator or divide by zero; ready stays low until the result reaches a free
// result register. Multiply and divide run a 32-step loop, one bit per cycle.
// Reset is synchronous, active high; it clears the expression and the result slot.
// A stalled result holds in the output register; keys keep flowing meanwhile, up to the next '='.
module keypad_expression_calculator_unit
   import kec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] key_code
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] result_value, [33:32] result_status
);

   typedef enum logic {
      T_IDLE,
      T_CALC
   } top_state_type;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_DONE
   } phase_type;

   top_state_type     state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [DATA_W-1:0] first_ff, first_in;
   logic              first_neg_ff, first_neg_in;
   logic              first_seen_ff, first_seen_in;
   logic [DATA_W-1:0] second_ff, second_in;
   logic              second_neg_ff, second_neg_in;
   logic              second_seen_ff, second_seen_in;
   op_type            opk_ff, opk_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;

   logic              key_take;
   logic [7:0]        key;
   logic              is_op;
   op_type            key_op;
   logic [DATA_W-1:0] fold_src;
   logic [DATA_W-1:0] folded;
   logic              slot_free;

   assign key       = req_tdata;
   assign key_take  = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      is_op  = 1'b1;
      key_op = OP_ADD;
      unique case (key)
         KEY_PLUS:  key_op = OP_ADD;
         KEY_MINUS: key_op = OP_SUB;
         KEY_STAR:  key_op = OP_MUL;
         KEY_SLASH: key_op = OP_DIV;
         default:   is_op  = 1'b0;
      endcase
   end

   // acc*10 + key - '0', wrapping
   assign fold_src = (phase_ff == PH_FIRST) ? first_ff : second_ff;
   assign folded   = {fold_src[DATA_W-4:0], 3'b000} + {fold_src[DATA_W-2:0], 1'b0}
                   + {{(DATA_W-8){1'b0}}, key} - {{(DATA_W-8){1'b0}}, KEY_ZERO};

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      first_in       = first_ff;
      first_neg_in   = first_neg_ff;
      first_seen_in  = first_seen_ff;
      second_in      = second_ff;
      second_neg_in  = second_neg_ff;
      second_seen_in = second_seen_ff;
      opk_in         = opk_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;

      alu_req.start  = 1'b0;
      alu_req.op     = (phase_ff == PH_FIRST) ? OP_NONE : opk_ff;
      alu_req.a      = first_neg_ff ? -first_ff : first_ff;
      alu_req.b      = second_neg_ff ? -second_ff : second_ff;

      unique case (state_ff)
         T_IDLE: begin
            if (key_take && key != KEY_NONE) begin
               if (phase_ff != PH_FIRST && phase_ff != PH_SECOND) begin
                  // done: only clear counts
                  if (key == KEY_CLEAR) begin
                     phase_in       = PH_FIRST;
                     first_in       = '0;
                     first_neg_in   = 1'b0;
                     first_seen_in  = 1'b0;
                     second_in      = '0;
                     second_neg_in  = 1'b0;
                     second_seen_in = 1'b0;
                     opk_in         = OP_ADD;
                  end
               end else if (key == KEY_EQ) begin
                  alu_req.start = 1'b1;
                  phase_in      = PH_DONE;
                  state_in      = T_CALC;
               end else if (phase_ff == PH_FIRST) begin
                  if (!first_seen_ff) begin
                     first_seen_in = 1'b1;
                     if (key == KEY_MINUS) first_neg_in = 1'b1;
                     else                  first_in     = folded;
                  end else if (is_op) begin
                     opk_in   = key_op;
                     phase_in = PH_SECOND;
                  end else begin
                     first_in = folded;
                  end
               end else begin
                  second_seen_in = 1'b1;
                  if (!second_seen_ff && key == KEY_MINUS) second_neg_in = 1'b1;
                  else                                     second_in     = folded;
               end
            end
         end
         T_CALC: begin
            if (alu_rsp.valid && slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = alu_rsp.value;
               rsp_status_in = alu_rsp.status;
               state_in      = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= T_IDLE;
         phase_ff       <= PH_FIRST;
         first_ff       <= '0;
         first_neg_ff   <= 1'b0;
         first_seen_ff  <= 1'b0;
         second_ff      <= '0;
         second_neg_ff  <= 1'b0;
         second_seen_ff <= 1'b0;
         opk_ff         <= OP_ADD;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         first_ff       <= first_in;
         first_neg_ff   <= first_neg_in;
         first_seen_ff  <= first_seen_in;
         second_ff      <= second_in;
         second_neg_ff  <= second_neg_in;
         second_seen_ff <= second_seen_in;
         opk_ff         <= opk_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   kec_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   assign req_tready = (state_ff == T_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_status_ff, rsp_value_ff};

   // a new result word only comes out of a calculation
   a_rsp_from_calc: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == T_CALC))
      else $error("result word without calculation");

   // while calculating the expression is already closed
   a_calc_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_CALC) |-> (phase_ff == PH_DONE))
      else $error("calculation with open expression");

   // the second operand only grows once an operator was taken
   a_second_phase: assert property (@(posedge clock) disable iff (reset)
      second_seen_ff |-> (phase_ff != PH_FIRST))
      else $error("second operand touched in first phase");

endmodule

[test/tb_keypad_expression_calculator_unit.sv]
`timescale 1ns / 100ps

module tb_keypad_expression_calculator_unit;
   import kec_pkg::*;

   // ---------------------------------------------------------------------------
   // Types
   // ---------------------------------------------------------------------------
   typedef enum logic [1:0] {
      PH_FIRST,                      // building the first operand
      PH_SECOND,                     // operator seen, building the second operand
      PH_DONE                        // result given, only 'c' has an effect
   } calc_phase_type;

   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  status;
   } calc_result_type;

   // one row of the directed table; hard_exp marks a result typed in by hand
   typedef struct packed {
      logic [7:0]      key;
      logic            hard_exp;
      calc_result_type result;
   } key_row_type;

   localparam int CLK_HALF    = 10;
   localparam int KEY_TARGET  = 1150;     // live keys before the random part stops
   localparam int TAIL_CYCLES = 80;       // longer than the slowest '=' (divide)
   localparam int CYCLE_LIMIT = 400000;

   // ---------------------------------------------------------------------------
   // DUT hookup
   // ---------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;        // [7:0] key_code
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;        // [31:0] result_value, [33:32] result_status

   keypad_expression_calculator_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #CLK_HALF clock = ~clock;

   // ---------------------------------------------------------------------------
   // Calculator predictor: own copy of the expression state
   // ---------------------------------------------------------------------------
   calc_phase_type  calc_phase;
   logic [31:0]     first_mag;
   logic            first_neg;
   logic            first_seen;
   logic [31:0]     second_mag;
   logic            second_neg;
   logic            second_seen;
   op_type          calc_op;

   calc_result_type calc_expect [$];  // results owed by the block, oldest first
   key_row_type     key_table [$];    // directed stimulus

   int  live_keys  = 0;            // keys that changed state (not ignored ones)
   int  fail_count = 0;
   int  cycle_count = 0;
   bit  quiet = 1'b0;              // no gaps and no stalls while set

   function automatic logic [31:0] fold_key(logic [31:0] acc, logic [7:0] key);
      return acc * 32'd10 + {24'd0, key} - {24'd0, KEY_ZERO};
   endfunction

   function automatic logic [31:0] apply_sign(logic [31:0] mag, logic neg);
      return neg ? -mag : mag;
   endfunction

   task automatic clear_calc();
      calc_phase  = PH_FIRST;
      first_mag   = '0;
      first_neg   = 1'b0;
      first_seen  = 1'b0;
      second_mag  = '0;
      second_neg  = 1'b0;
      second_seen = 1'b0;
      calc_op     = OP_ADD;
   endtask

   // advance the predictor by one accepted key; '=' before the done phase queues one result
   task automatic calc_key(input logic [7:0] key);
      logic [31:0]     a;
      logic [31:0]     b;
      logic [31:0]     ua;
      logic [31:0]     ub;
      logic [31:0]     q;
      calc_result_type res;
      if (key == KEY_NONE)
         return;
      // done phase: everything but 'c' falls on the floor
      if (calc_phase == PH_DONE) begin
         if (key == KEY_CLEAR) begin
            live_keys++;
            clear_calc();
         end
         return;
      end
      live_keys++;
      if (key == KEY_EQ) begin
         res.value  = '0;
         res.status = ST_OK;
         if (calc_phase == PH_FIRST) begin
            res.status = ST_NOOP;
         end else begin
            a = apply_sign(first_mag, first_neg);
            b = apply_sign(second_mag, second_neg);
            case (calc_op)
               OP_ADD: res.value = a + b;
               OP_SUB: res.value = a - b;
               OP_MUL: res.value = a * b;
               default: begin
                  if (b == '0) begin
                     res.status = ST_DIV0;
                  end else begin
                     // sign-magnitude divide, truncates toward zero;
                     // most negative / -1 wraps back to itself
                     ua = a[31] ? -a : a;
                     ub = b[31] ? -b : b;
                     q  = ua / ub;
                     res.value = (a[31] ^ b[31]) ? -q : q;
                  end
               end
            endcase
         end
         calc_phase = PH_DONE;
         calc_expect.push_back(res);
         return;
      end
      if (calc_phase == PH_FIRST) begin
         if (!first_seen) begin
            // very first key: '-' is a sign, anything else (ops too) is a digit
            first_seen = 1'b1;
            if (key == KEY_MINUS)
               first_neg = 1'b1;
            else
               first_mag = fold_key(first_mag, key);
         end else begin
            case (key)
               KEY_PLUS: begin
                  calc_op = OP_ADD;
                  calc_phase = PH_SECOND;
               end
               KEY_MINUS: begin
                  calc_op = OP_SUB;
                  calc_phase = PH_SECOND;
               end
               KEY_STAR: begin
                  calc_op = OP_MUL;
                  calc_phase = PH_SECOND;
               end
               KEY_SLASH: begin
                  calc_op = OP_DIV;
                  calc_phase = PH_SECOND;
               end
               default: first_mag = fold_key(first_mag, key);
            endcase
         end
      end else begin
         // second operand: leading '-' is a sign, all else folds in
         if (!second_seen && key == KEY_MINUS) begin
            second_neg = 1'b1;
         end else begin
            second_mag = fold_key(second_mag, key);
         end
         second_seen = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Key driver: random gap, then hold the word until the block takes it
   // ---------------------------------------------------------------------------
   task automatic press(input logic [7:0] key);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      calc_key(key);
   endtask

   // decimal digits of a magnitude; an empty operand is allowed
   task automatic press_number(input logic [31:0] mag);
      string digits;
      digits = $sformatf("%0d", mag);
      for (int i = 0; i < digits.len(); i++)
         press(digits[i]);
   endtask

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'h7fff_ffff;
         3: return 32'h8000_0000;
         4: return 32'hffff_ffff;
         5: return $urandom;
         default: return $urandom_range(0, 999);
      endcase
   endfunction

   function automatic logic [7:0] pick_op_key();
      case ($urandom_range(0, 3))
         0: return KEY_PLUS;
         1: return KEY_MINUS;
         2: return KEY_STAR;
         default: return KEY_SLASH;
      endcase
   endfunction

   task automatic add_row(input logic [7:0] key, input logic hard_exp,
                          input logic [31:0] value, input logic [1:0] status);
      key_row_type row;
      row.key           = key;
      row.hard_exp      = hard_exp;
      row.result.value  = value;
      row.result.status = status;
      key_table.push_back(row);
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin
      logic [31:0] mag;
      logic [7:0]  op_key;
      bit          corner;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      clear_calc();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: no-key, '=' with no operator, done-phase junk, divide by zero,
      // operator as first key, 'c' and extra op folded into the second operand,
      // lone signs as empty operands, extreme key codes
      add_row(KEY_NONE,          1'b0, 32'd0, ST_OK);
      add_row(KEY_EQ,            1'b1, 32'd0, ST_NOOP);
      add_row(KEY_ZERO + 8'd7,   1'b0, 32'd0, ST_OK);
      add_row(KEY_CLEAR,         1'b0, 32'd0, ST_OK);
      add_row(KEY_MINUS,         1'b0, 32'd0, ST_OK);
      add_row(KEY_ZERO + 8'd9,   1'b0, 32'd0, ST_OK);
      add_row(KEY_SLASH,         1'b0, 32'd0, ST_OK);
      add_row(KEY_ZERO,          1'b0, 32'd0, ST_OK);
      add_row(KEY_EQ,            1'b1, 32'd0, ST_DIV0);
      add_row(KEY_CLEAR,         1'b0, 32'd0, ST_OK);
      add_row(KEY_STAR,          1'b0, 32'd0, ST_OK);
      add_row(KEY_MINUS,         1'b0, 32'd0, ST_OK);
      add_row(KEY_MINUS,         1'b0, 32'd0, ST_OK);
      add_row(KEY_CLEAR,         1'b0, 32'd0, ST_OK);
      add_row(KEY_PLUS,          1'b0, 32'd0, ST_OK);
      add_row(KEY_NONE,          1'b0, 32'd0, ST_OK);
      add_row(KEY_EQ,            1'b0, 32'd0, ST_OK);
      add_row(KEY_CLEAR,         1'b0, 32'd0, ST_OK);
      add_row(8'h00,             1'b0, 32'd0, ST_OK);
      add_row(8'hfe,             1'b0, 32'd0, ST_OK);
      add_row(KEY_SLASH,         1'b0, 32'd0, ST_OK);
      add_row(KEY_MINUS,         1'b0, 32'd0, ST_OK);
      add_row(KEY_EQ,            1'b1, 32'd0, ST_DIV0);
      add_row(KEY_CLEAR,         1'b0, 32'd0, ST_OK);
      add_row(KEY_MINUS,         1'b0, 32'd0, ST_OK);
      add_row(KEY_PLUS,          1'b0, 32'd0, ST_OK);
      add_row(KEY_EQ,            1'b1, 32'd0, ST_OK);
      add_row(KEY_CLEAR,         1'b0, 32'd0, ST_OK);

      foreach (key_table[i]) begin
         press(key_table[i].key);
         // hand-typed result replaces the predicted one still waiting at the tail
         if (key_table[i].hard_exp)
            calc_expect[calc_expect.size() - 1] = key_table[i].result;
      end

      // random: mostly well-formed "a op b =" with random content, some noise
      while (live_keys < KEY_TARGET) begin
         quiet = ($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 99) < 80) begin
            corner = ($urandom_range(0, 19) == 0);   // most negative / -1
            if ($urandom_range(0, 7) == 0)
               press(KEY_NONE);
            if (corner || $urandom_range(0, 2) == 0)
               press(KEY_MINUS);
            mag = corner ? 32'h8000_0000 : pick_operand();
            if (corner || $urandom_range(0, 9) != 0)
               press_number(mag);
            op_key = corner ? KEY_SLASH : pick_op_key();
            press(op_key);
            if ($urandom_range(0, 7) == 0)
               press(KEY_NONE);
            if (corner || $urandom_range(0, 2) == 0)
               press(KEY_MINUS);
            mag = corner ? 32'd1 : pick_operand();
            if (corner || $urandom_range(0, 9) != 0)
               press_number(mag);
            if ($urandom_range(0, 7) == 0)
               press(8'($urandom_range(0, 254)));
            press(KEY_EQ);
            if ($urandom_range(0, 3) == 0)
               press(8'($urandom_range(0, 255)));
            press(KEY_CLEAR);
         end else begin
            // broken sequence of arbitrary keys, then back to a clean state
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(0, 5))
                  0: press(pick_op_key());
                  1: press(KEY_EQ);
                  2: press(KEY_CLEAR);
                  3: press(KEY_NONE);
                  4: press(KEY_ZERO + 8'($urandom_range(0, 9)));
                  default: press(8'($urandom_range(0, 255)));
               endcase
            end
            if (calc_phase != PH_DONE)
               press(KEY_EQ);
            press(KEY_CLEAR);
         end
      end
      req_tvalid <= 1'b0;

      // drain: all owed results, then a quiet tail for anything unexpected
      while (calc_expect.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Result receiver and checker
   // ---------------------------------------------------------------------------
   initial begin
      int              stall;
      calc_result_type got;
      calc_result_type want;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
         got.value  = rsp_tdata[31:0];
         got.status = rsp_tdata[33:32];
         if (calc_expect.size() == 0) begin
            $error("unexpected result word: value %0d status %0d",
                   $signed(got.value), got.status);
            fail_count++;
         end else begin
            want = calc_expect.pop_front();
            if (got.value !== want.value) begin
               $error("result_value: expected %0d, got %0d",
                      $signed(want.value), $signed(got.value));
               fail_count++;
            end
            if (got.status !== want.status) begin
               $error("result_status: expected %0d, got %0d", want.status, got.status);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule

[sim.f]
design/kec_pkg.sv
design/kec_alu.sv
design/keypad_expression_calculator_unit.sv
test/tb_keypad_expression_calculator_unit.sv
